### rtl/slot_table_linked_list_top_assert.svh
// Assertion macros for the slot table linked list checker.
// Used by stll_checker.sv; expects clk and rst in scope.
`ifndef SLOT_TABLE_LINKED_LIST_TOP_ASSERT_SVH
`define SLOT_TABLE_LINKED_LIST_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define STLL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define STLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/stll_pkg.sv
// Shared constants, codes and structs for the slot table linked list.
// No dependencies; imported by every module of the block but stll_ram.
package stll_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);

  localparam int CMD_W    = 3;
  localparam int COORD_W  = 32;
  localparam int XY_W     = 2 * COORD_W;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TOP    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic start;
    logic match;   // 1: look for used slot equal to key, 0: look for free slot
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage

### rtl/stll_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module stll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/stll_scan.sv
// Slot scan unit: walks slots 0..CAPACITY-1 looking for the lowest free
// slot or the lowest used slot whose coordinates equal the key. Uses stll_pkg.
module stll_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  stll_pkg::scan_ctl_t            ctl,
  input  logic [stll_pkg::XY_W-1:0]      key,
  input  logic [stll_pkg::CAPACITY-1:0]  used,
  input  logic [stll_pkg::XY_W-1:0]      rd_data,
  output logic [stll_pkg::IDX_W-1:0]     rd_addr,
  output logic                           busy,
  output stll_pkg::scan_res_t            res
);
  import stll_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic             issuing;
  logic             match_mode;
  logic [IDX_W-1:0] addr;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_cond;

  // RAM data arrives in the cycle after its address is issued
  always_comb begin
    hit_cond = match_mode ? (used[cmp_idx] && (rd_data == key)) : !used[cmp_idx];
    res.done = busy && cmp_valid && (hit_cond || (cmp_idx == LAST_IDX));
    res.hit  = cmp_valid && hit_cond;
    res.idx  = cmp_idx;
  end

  assign rd_addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      issuing    <= 1'b0;
      cmp_valid  <= 1'b0;
      match_mode <= 1'b0;
      addr       <= '0;
      cmp_idx    <= '0;
    end else if (ctl.start) begin
      busy       <= 1'b1;
      issuing    <= 1'b1;
      cmp_valid  <= 1'b0;
      match_mode <= ctl.match;
      addr       <= '0;
    end else if (busy) begin
      if (res.done) begin
        busy      <= 1'b0;
        issuing   <= 1'b0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= issuing;
        cmp_idx   <= addr;
        if (issuing) begin
          if (addr == LAST_IDX) begin
            issuing <= 1'b0;
          end else begin
            addr <= addr + 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/slot_table_linked_list_top.sv
// Top level of the slot table linked list: command sequencer, link update,
// result register. Uses stll_pkg, stll_scan and stll_ram.
//
//  channel  | signals                  | word
//  ---------+--------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata| cmd, x_coord, y_coord
//  output   | m_tvalid m_tready m_tdata| status, count, head_valid, head_x, head_y
//
// Append, push and remove run one slot scan, one slot a cycle through the
// coordinate RAM read port, stopping at the first hit; pop reads the head
// first, then runs the same scan for its coordinates. Top, full, empty and
// unused codes go through S_FIN_RD to S_FIN. One command at a time;
// s_tready is low until the result is loaded into the output register.
// Reset clears the used bits and list pointers at once; no clearing pass. A
// stalled output holds the result and the next command may be taken meanwhile.
module slot_table_linked_list_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] cmd, [34:3] x_coord, [66:35] y_coord, [71:67] zero
  input  logic [stll_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [9:2] count, [10] head_valid, [42:11] head_x,
  // [74:43] head_y, [79:75] zero
  output logic [stll_pkg::M_DATA_W-1:0] m_tdata
);
  import stll_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_HEAD_RD  = 10'b0000000010,
    S_POP_KEY  = 10'b0000000100,
    S_SCAN     = 10'b0000001000,
    S_INS_SELF = 10'b0000010000,
    S_INS_NBR  = 10'b0000100000,
    S_LINK_RD  = 10'b0001000000,
    S_UNLINK   = 10'b0010000000,
    S_FIN_RD   = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } fsm_t;

  fsm_t                state, state_next;
  logic [CMD_W-1:0]    cmd, cmd_next;
  logic [XY_W-1:0]     key, key_next;
  logic [STAT_W-1:0]   status, status_next;
  logic [IDX_W-1:0]    slot, slot_next;
  logic [IDX_W-1:0]    head_index, head_next;
  logic [IDX_W-1:0]    tail_index, tail_next;
  logic [LINK_W-1:0]   entry_count, count_next;
  logic [CAPACITY-1:0] slot_used, used_next;

  logic                out_load;
  logic                head_valid;
  logic [COORD_W-1:0]  head_x, head_y;

  scan_ctl_t           scan_ctl;
  scan_res_t           scan_res;
  logic                scan_busy;
  logic [IDX_W-1:0]    scan_addr;

  logic                xy_we;
  logic [IDX_W-1:0]    xy_waddr, xy_raddr;
  logic [XY_W-1:0]     xy_rdata;
  logic                nl_we, pl_we;
  logic [IDX_W-1:0]    nl_waddr, pl_waddr;
  logic [LINK_W-1:0]   nl_wdata, pl_wdata, nl_rdata, pl_rdata;

  logic [CMD_W-1:0]    in_cmd;
  logic [XY_W-1:0]     in_xy;
  logic                is_insert;

  assign in_cmd    = s_tdata[CMD_W-1:0];
  assign in_xy     = s_tdata[CMD_W +: XY_W];   // {y, x}
  assign s_tready  = (state == S_IDLE);
  assign is_insert = (cmd == CMD_APPEND) || (cmd == CMD_PUSH);
  assign xy_raddr  = scan_busy ? scan_addr : head_index;

  stll_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .key     (key),
    .used    (slot_used),
    .rd_data (xy_rdata),
    .rd_addr (scan_addr),
    .busy    (scan_busy),
    .res     (scan_res)
  );

  stll_ram #(.WIDTH(XY_W), .DEPTH(CAPACITY)) u_xy_ram (
    .clk   (clk),
    .we    (xy_we),
    .waddr (xy_waddr),
    .wdata (key),
    .raddr (xy_raddr),
    .rdata (xy_rdata)
  );

  stll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (slot),
    .rdata (nl_rdata)
  );

  stll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (slot),
    .rdata (pl_rdata)
  );

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    key_next    = key;
    status_next = status;
    slot_next   = slot;
    head_next   = head_index;
    tail_next   = tail_index;
    count_next  = entry_count;
    used_next   = slot_used;
    scan_ctl    = '0;
    xy_we       = 1'b0;
    xy_waddr    = slot;
    nl_we       = 1'b0;
    nl_waddr    = slot;
    nl_wdata    = LINK_NONE;
    pl_we       = 1'b0;
    pl_waddr    = slot;
    pl_wdata    = LINK_NONE;
    out_load    = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_next    = in_cmd;
          key_next    = in_xy;
          status_next = ST_OK;
          case (in_cmd)
            CMD_APPEND, CMD_PUSH: begin
              if (entry_count == LINK_W'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_FIN_RD;
              end else begin
                scan_ctl.start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              scan_ctl.start = 1'b1;
              scan_ctl.match = 1'b1;
              state_next     = S_SCAN;
            end
            CMD_POP: begin
              if (entry_count == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_FIN_RD;
              end else begin
                state_next = S_HEAD_RD;
              end
            end
            CMD_TOP: begin
              status_next = (entry_count == '0) ? ST_EMPTY : ST_OK;
              state_next  = S_FIN_RD;
            end
            default: begin
              state_next = S_FIN_RD;
            end
          endcase
        end
      end
      S_HEAD_RD: begin
        state_next = S_POP_KEY;
      end
      S_POP_KEY: begin
        // pop searches for the head's coordinates
        key_next       = xy_rdata;
        scan_ctl.start = 1'b1;
        scan_ctl.match = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          slot_next = scan_res.idx;
          if (is_insert) begin
            state_next = S_INS_SELF;
          end else if (scan_res.hit) begin
            state_next = S_LINK_RD;
          end else begin
            status_next = ST_NOMATCH;
            state_next  = S_FIN_RD;
          end
        end
      end
      S_INS_SELF: begin
        xy_we           = 1'b1;
        used_next[slot] = 1'b1;
        count_next      = entry_count + 1'b1;
        nl_we           = 1'b1;
        pl_we           = 1'b1;
        if (entry_count == '0) begin
          head_next  = slot;
          tail_next  = slot;
          state_next = S_FIN_RD;
        end else if (cmd == CMD_PUSH) begin
          nl_wdata   = LINK_W'(head_index);
          state_next = S_INS_NBR;
        end else begin
          pl_wdata   = LINK_W'(tail_index);
          state_next = S_INS_NBR;
        end
      end
      S_INS_NBR: begin
        if (cmd == CMD_PUSH) begin
          pl_we     = 1'b1;
          pl_waddr  = head_index;
          pl_wdata  = LINK_W'(slot);
          head_next = slot;
        end else begin
          nl_we     = 1'b1;
          nl_waddr  = tail_index;
          nl_wdata  = LINK_W'(slot);
          tail_next = slot;
        end
        state_next = S_FIN_RD;
      end
      S_LINK_RD: begin
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        used_next[slot] = 1'b0;
        if (pl_rdata < LINK_NONE) begin
          nl_we    = 1'b1;
          nl_waddr = pl_rdata[IDX_W-1:0];
          nl_wdata = nl_rdata;
        end else begin
          head_next = (nl_rdata < LINK_NONE) ? nl_rdata[IDX_W-1:0] : '0;
        end
        if (nl_rdata < LINK_NONE) begin
          pl_we    = 1'b1;
          pl_waddr = nl_rdata[IDX_W-1:0];
          pl_wdata = pl_rdata;
        end else begin
          tail_next = (pl_rdata < LINK_NONE) ? pl_rdata[IDX_W-1:0] : '0;
        end
        if (entry_count != '0) begin
          count_next = entry_count - 1'b1;
        end
        state_next = S_FIN_RD;
      end
      S_FIN_RD: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign head_valid = (entry_count != '0);
  assign head_x     = head_valid ? xy_rdata[COORD_W-1:0] : '0;
  assign head_y     = head_valid ? xy_rdata[XY_W-1:COORD_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
      slot_used   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      head_index  <= head_next;
      tail_index  <= tail_next;
      entry_count <= count_next;
      slot_used   <= used_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    key    <= key_next;
    status <= status_next;
    slot   <= slot_next;
    if (out_load) begin
      m_tdata <= {{(M_DATA_W - STAT_W - COUNT_W - 1 - XY_W){1'b0}},
                  head_y, head_x, head_valid, COUNT_W'(entry_count), status};
    end
  end

endmodule

### rtl/stll_checker.sv
// Port-level checker for slot_table_linked_list_top, attached by bind.
// Uses stll_pkg and the macros in slot_table_linked_list_top_assert.svh.
`include "slot_table_linked_list_top_assert.svh"

module stll_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [stll_pkg::M_DATA_W-1:0] m_tdata
);
  import stll_pkg::*;

  logic                in_take;
  logic                hv;
  logic [STAT_W-1:0]   st;
  logic [XY_W-1:0]     hxy;

  assign in_take = s_tvalid && s_tready;
  assign hv      = m_tdata[STAT_W + COUNT_W];
  assign st      = m_tdata[STAT_W-1:0];
  assign hxy     = m_tdata[STAT_W + COUNT_W + 1 +: XY_W];

  // one command at a time: a taken word closes the input side
  `STLL_ASSERT_NEXT(a_one_cmd, in_take, !s_tready, "input taken while command busy")

  // a result held under stall stays
  `STLL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "stalled result changed")

  // an empty list reports zero coordinates
  `STLL_ASSERT_SAME(a_empty_zero, m_tvalid && !hv, hxy == '0,
    "head coordinates nonzero on empty list")

  // list-empty status only when no head remains
  `STLL_ASSERT_SAME(a_empty_stat, m_tvalid && (st == ST_EMPTY), !hv,
    "empty status with a valid head")

endmodule

bind slot_table_linked_list_top stll_checker u_stll_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/tb_slot_table_linked_list_top.sv
// Self-checking bench for slot_table_linked_list_top: table-driven directed words, then
// fill/drain/mixed random phases checked against an in-bench list tracker.
// Depends on stll_pkg and the RTL of the block only.
module tb_slot_table_linked_list_top;
  import stll_pkg::*;

  localparam int          HALF_PERIOD = 5;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          N_RANDOM    = 1250;
  localparam int          LONG_HOLD   = 600;
  localparam int          TAIL_WAIT   = 20;
  localparam int          DRAIN_GUARD = 5000;

  // codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic                      head_valid;
    logic signed [COORD_W-1:0] head_x;
    logic signed [COORD_W-1:0] head_y;
  } list_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      typed;
    list_word_t                want;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  localparam list_word_t EMPTY_WORD = '{ST_EMPTY, 8'd0, 1'b0, 32'sd0, 32'sd0};

  localparam dir_row_t DIR_TAB [24] = '{
    '{CMD_TOP,    32'sd0,   32'sd0,   1'b1, EMPTY_WORD},
    '{CMD_POP,    32'sd0,   32'sd0,   1'b1, EMPTY_WORD},
    '{CMD_REMOVE, 32'sd0,   32'sd0,   1'b1, '{ST_NOMATCH, 8'd0, 1'b0, 32'sd0, 32'sd0}},
    '{CMD_SPARE5, C_MAX,    C_MIN,    1'b1, '{ST_OK, 8'd0, 1'b0, 32'sd0, 32'sd0}},
    '{CMD_APPEND, C_MAX,    C_MIN,    1'b1, '{ST_OK, 8'd1, 1'b1, C_MAX, C_MIN}},
    '{CMD_PUSH,   C_MIN,    C_MAX,    1'b1, '{ST_OK, 8'd2, 1'b1, C_MIN, C_MAX}},
    '{CMD_APPEND, -32'sd1,  -32'sd1,  1'b0, '0},
    '{CMD_APPEND, 32'sd0,   32'sd0,   1'b0, '0},
    '{CMD_PUSH,   32'sd5,   32'sd5,   1'b0, '0},
    '{CMD_APPEND, 32'sd5,   32'sd5,   1'b0, '0},
    '{CMD_APPEND, C_MIN,    C_MAX,    1'b0, '0},
    '{CMD_PUSH,   -32'sd1,  -32'sd1,  1'b0, '0},
    // head duplicates a lower slot: pop must take the lower slot, head stays
    '{CMD_POP,    32'sd0,   32'sd0,   1'b0, '0},
    '{CMD_REMOVE, 32'sd123, -32'sd456, 1'b0, '0},
    '{CMD_REMOVE, 32'sd0,   32'sd0,   1'b0, '0},
    '{CMD_SPARE6, -32'sd1,  -32'sd1,  1'b0, '0},
    '{CMD_SPARE7, C_MIN,    C_MAX,    1'b0, '0},
    '{CMD_TOP,    32'sd0,   32'sd0,   1'b0, '0},
    '{CMD_POP,    32'sd0,   32'sd0,   1'b0, '0},
    '{CMD_REMOVE, C_MIN,    C_MAX,    1'b0, '0},
    '{CMD_APPEND, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, '0},
    '{CMD_REMOVE, C_MAX,    C_MIN,    1'b0, '0},
    '{CMD_REMOVE, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, '0},
    '{CMD_TOP,    32'sd0,   32'sd0,   1'b0, '0}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // list tracker
  logic signed [COORD_W-1:0] pt_x [CAPACITY];
  logic signed [COORD_W-1:0] pt_y [CAPACITY];
  bit                        in_use [CAPACITY];
  int                        link_fwd [CAPACITY];
  int                        link_back [CAPACITY];
  int                        first_slot = 0;
  int                        last_slot  = 0;
  int                        n_entries  = 0;

  list_word_t  status_words [$];
  int          n_errors  = 0;
  bit          hold_req  = 1'b0;
  bit          no_idle   = 1'b0;
  int unsigned cycle_cnt = 0;

  always #HALF_PERIOD clk = ~clk;

  slot_table_linked_list_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic logic [STAT_W-1:0] list_insert(input bit at_head,
                                                    input logic signed [COORD_W-1:0] x, y);
    int s = 0;
    if (n_entries >= CAPACITY) return ST_FULL;
    while (in_use[s]) s++;
    pt_x[s]   = x;
    pt_y[s]   = y;
    in_use[s] = 1'b1;
    if (n_entries == 0) begin
      link_fwd[s]  = CAPACITY;
      link_back[s] = CAPACITY;
      first_slot   = s;
      last_slot    = s;
    end else if (at_head) begin
      link_back[s]          = CAPACITY;
      link_fwd[s]           = first_slot;
      link_back[first_slot] = s;
      first_slot            = s;
    end else begin
      link_fwd[s]          = CAPACITY;
      link_back[s]         = last_slot;
      link_fwd[last_slot]  = s;
      last_slot            = s;
    end
    n_entries++;
    return ST_OK;
  endfunction

  // unlinks the lowest used slot holding (x,y)
  function automatic logic [STAT_W-1:0] list_unlink(input logic signed [COORD_W-1:0] x, y);
    int nx, pv;
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_use[i] && pt_x[i] == x && pt_y[i] == y) begin
        nx        = link_fwd[i];
        pv        = link_back[i];
        in_use[i] = 1'b0;
        if (pv < CAPACITY) link_fwd[pv] = nx;
        else first_slot = (nx < CAPACITY) ? nx : 0;
        if (nx < CAPACITY) link_back[nx] = pv;
        else last_slot = (pv < CAPACITY) ? pv : 0;
        n_entries--;
        return ST_OK;
      end
    end
    return ST_NOMATCH;
  endfunction

  function automatic list_word_t list_apply(input logic [CMD_W-1:0] cmd,
                                            input logic signed [COORD_W-1:0] x, y);
    list_word_t w;
    case (cmd)
      CMD_APPEND: w.status = list_insert(1'b0, x, y);
      CMD_PUSH:   w.status = list_insert(1'b1, x, y);
      CMD_REMOVE: w.status = list_unlink(x, y);
      CMD_POP: begin
        if (n_entries == 0) w.status = ST_EMPTY;
        else w.status = list_unlink(pt_x[first_slot], pt_y[first_slot]);
      end
      CMD_TOP:    w.status = (n_entries == 0) ? ST_EMPTY : ST_OK;
      default:    w.status = ST_OK;
    endcase
    w.count      = COUNT_W'(n_entries);
    w.head_valid = (n_entries != 0);
    w.head_x     = w.head_valid ? pt_x[first_slot] : '0;
    w.head_y     = w.head_valid ? pt_y[first_slot] : '0;
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int r = $urandom_range(0, 99);
    if (r < 50) return COORD_W'($urandom_range(0, 6)) - 3;  // small pool, so removes hit
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return C_MIN;
        1:       return C_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [M_DATA_W-1:0] want, got);
    $display("%0t  %s: expected %0h, got %0h", $time, what, want, got);
    n_errors++;
  endtask

  // drives at falling edges; returns at the rising edge that takes the word
  task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [COORD_W-1:0] x, y,
                           input bit typed, input list_word_t want);
    int                  gap;
    logic [S_DATA_W-1:0] word;
    list_word_t          w;
    gap  = no_idle ? 0 : $urandom_range(0, 15);
    word = '0;
    word[CMD_W-1:0]                 = cmd;
    word[CMD_W+COORD_W-1:CMD_W]     = x;
    word[CMD_W+XY_W-1:CMD_W+COORD_W] = y;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    w = list_apply(cmd, x, y);
    status_words.push_back(typed ? want : w);
  endtask

  // withdraws the offered word at the next falling edge
  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin : sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    list_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = m_tdata[1:0];
      got.count      = m_tdata[9:2];
      got.head_valid = m_tdata[10];
      got.head_x     = m_tdata[42:11];
      got.head_y     = m_tdata[74:43];
      if (status_words.size() == 0) begin
        report_mismatch("word with nothing pending", '0, m_tdata);
      end else begin
        want = status_words.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", M_DATA_W'(want.status), M_DATA_W'(got.status));
        if (got.count !== want.count)
          report_mismatch("count", M_DATA_W'(want.count), M_DATA_W'(got.count));
        if (got.head_valid !== want.head_valid)
          report_mismatch("head_valid", M_DATA_W'(want.head_valid),
                          M_DATA_W'(got.head_valid));
        if (got.head_x !== want.head_x)
          report_mismatch("head_x", M_DATA_W'(want.head_x), M_DATA_W'(got.head_x));
        if (got.head_y !== want.head_y)
          report_mismatch("head_y", M_DATA_W'(want.head_y), M_DATA_W'(got.head_y));
      end
    end
  end

  initial begin : stimulus
    int                        n_done, steps, settle, k, r, guard, phase_no;
    int                        cuts [5];
    phase_t                    mode;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x, y;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIR_TAB[i])
      issue_cmd(DIR_TAB[i].cmd, DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].typed, DIR_TAB[i].want);

    // let every result come back, then starve the output so the input backs up
    drop_valid();
    while (status_words.size() != 0) @(negedge clk);
    hold_req = 1'b1;

    n_done   = 0;
    phase_no = 0;
    while (n_done < N_RANDOM) begin
      mode = phase_t'(phase_no % 3);
      phase_no++;
      no_idle = ($urandom_range(0, 3) == 0);
      case (mode)
        PH_FILL:  cuts = '{45, 85, 90, 94, 98};
        PH_DRAIN: cuts = '{8, 20, 60, 88, 95};
        default:  cuts = '{20, 40, 65, 80, 94};
      endcase
      steps  = 0;
      settle = 0;
      while (settle < 8 && steps < 400 && n_done < N_RANDOM) begin
        r = $urandom_range(0, 99);
        if (r < cuts[0])      cmd = CMD_APPEND;
        else if (r < cuts[1]) cmd = CMD_PUSH;
        else if (r < cuts[2]) cmd = CMD_REMOVE;
        else if (r < cuts[3]) cmd = CMD_POP;
        else if (r < cuts[4]) cmd = CMD_TOP;
        else                  cmd = CMD_W'($urandom_range(CMD_SPARE5, CMD_SPARE7));
        x = pick_coord();
        y = pick_coord();
        // mostly remove a point that is actually stored
        if (cmd == CMD_REMOVE && n_entries != 0 && $urandom_range(0, 99) < 70) begin
          k = $urandom_range(0, CAPACITY - 1);
          while (!in_use[k]) k = (k + 1) % CAPACITY;
          x = pt_x[k];
          y = pt_y[k];
        end
        issue_cmd(cmd, x, y, 1'b0, '0);
        steps++;
        if (cmd <= CMD_TOP) n_done++;
        if ((mode == PH_FILL && n_entries == CAPACITY) ||
            (mode == PH_DRAIN && n_entries == 0) ||
            (mode == PH_MIX && steps >= 120))
          settle++;
      end
      if ($urandom_range(0, 3) == 0) begin
        drop_valid();
        while (status_words.size() != 0) @(negedge clk);
      end
    end
    drop_valid();

    guard = 0;
    while (status_words.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (status_words.size() != 0)
      report_mismatch("results never delivered", M_DATA_W'(status_words.size()), '0);

    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
